// ===== sv/rsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsrd_pkg
// shared types and constants for the rgbe scanline run-length decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rsrd_pkg;

  localparam int DimW = 15;
  localparam int ChW  = 2;
  localparam int LenW = 8;
  localparam int ByteW = 8;
  localparam int HdrW = 2;

  localparam logic [HdrW-1:0]  HdrLast   = 2'd3;
  localparam logic [ChW-1:0]   ChLast    = 2'd3;
  localparam logic [ByteW-1:0] RunMarker = 8'd128;

  // register indexes
  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_COUNT,
    PH_RUN,
    PH_LITERAL,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } dims_t;

  typedef struct packed {
    logic             format_error;
    logic             image_done;
    logic             row_done;
    logic [ByteW-1:0] byte_value;
    logic [LenW-1:0]  run_length;
    logic [DimW-1:0]  start_column;
    logic [ChW-1:0]   channel_index;
    logic [DimW-1:0]  row_index;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/rgbe_scanline_rle_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder_unit
// run-length scanline decoder for the pixel body of an rgbe image
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tdata: stream_byte
//  out_     out  out_tvalid/out_tready tdata: row, channel, column, length,
//                                     value; tlast: row_done;
//                                     tuser: image_done, format_error
//  cfg_     in   cfg_we               cfg_index, cfg_wdata
//
//  one byte per cycle sustained while out_ is not stalled; a result, where
//  a byte yields one, goes from the byte register to the result register
//  the byte register and the result register each hold one request
//  bytes advance whenever the result register is empty or being drained
//  synchronous active-low reset; no clearing pass, the block is ready at once
// ----------------------------------------------------------------------------
`default_nettype none

module rgbe_scanline_rle_decoder_unit #(
  parameter int MAX_DIM = 32767
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] stream_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [14:0] row_index, [16:15] channel_index,
                                       // [31:17] start_column, [39:32] run_length,
                                       // [47:40] byte_value
  output logic             out_tlast,  // row_done
  output logic [1:0]       out_tuser,  // [0] image_done, [1] format_error
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [14:0] cfg_wdata
);
  import rsrd_pkg::*;

  dims_t            dims;
  result_t          res;
  logic             res_valid;

  logic             in_valid_r, in_valid_nxt;
  logic [ByteW-1:0] in_byte_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;
  logic             drain;
  logic             step;
  logic             in_fire;

  rsrd_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dims      (dims)
  );

  rsrd_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (in_byte_r),
    .dims      (dims),
    .res       (res),
    .res_valid (res_valid)
  );

  assign drain     = !out_valid_r || out_tready;
  assign step      = in_valid_r && drain;
  assign in_tready = !in_valid_r || drain;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = drain ? res_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
    end
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.byte_value, out_res_r.run_length, out_res_r.start_column,
                       out_res_r.channel_index, out_res_r.row_index};
  assign out_tlast  = out_res_r.row_done;
  assign out_tuser  = {out_res_r.format_error, out_res_r.image_done};

endmodule

`default_nettype wire

// ===== sv/rsrd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rsrd_cfg_regs
// image width and height registers, clamped to MAX_DIM on write
// ----------------------------------------------------------------------------
`default_nettype none

module rsrd_cfg_regs #(
  parameter int MAX_DIM = 32767
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [rsrd_pkg::DimW-1:0] cfg_wdata,
  output rsrd_pkg::dims_t              dims
);
  import rsrd_pkg::*;

  localparam logic [DimW:0] MaxDimW = (DimW+1)'(MAX_DIM);

  logic [DimW-1:0] clamped;
  dims_t           dims_r;
  dims_t           dims_nxt;

  assign clamped = ({1'b0, cfg_wdata} > MaxDimW) ? MaxDimW[DimW-1:0] : cfg_wdata;

  always_comb begin
    dims_nxt = dims_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CfgWidth:  dims_nxt.width  = clamped;
        CfgHeight: dims_nxt.height = clamped;
        default:   dims_nxt = dims_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.width  <= DimW'(1024);
      dims_r.height <= DimW'(512);
    end else begin
      dims_r <= dims_nxt;
    end
  end

  assign dims = dims_r;

endmodule

`default_nettype wire

// ===== sv/rsrd_decode.sv =====
// ----------------------------------------------------------------------------
// rsrd_decode
// per-byte decode state and result formation for the run-length scanline body
// ----------------------------------------------------------------------------
`default_nettype none

module rsrd_decode (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic [rsrd_pkg::ByteW-1:0] byte_in,
  input  wire rsrd_pkg::dims_t          dims,
  output rsrd_pkg::result_t             res,
  output logic                          res_valid
);
  import rsrd_pkg::*;

  phase_t          phase_r, phase_nxt;
  logic [HdrW-1:0] hdr_r, hdr_nxt;
  logic [DimW-1:0] col_r, col_nxt;
  logic [ChW-1:0]  ch_r, ch_nxt;
  logic [DimW-1:0] row_r, row_nxt;
  logic [LenW-1:0] pend_r, pend_nxt;

  logic            is_run_cnt;
  logic [LenW-1:0] cnt_len;
  logic [DimW-1:0] room;
  logic            cnt_err;
  logic [LenW-1:0] step_len;
  logic [DimW-1:0] col_new;
  logic            plane_end;
  logic            last_ch;
  logic [DimW-1:0] row_inc;
  logic            img_end;
  logic [LenW-1:0] pend_dec;
  logic            lit_last;
  logic            do_adv;

  assign is_run_cnt = byte_in > RunMarker;
  assign cnt_len    = is_run_cnt ? {1'b0, byte_in[ByteW-2:0]} : byte_in;
  assign room       = (col_r < dims.width) ? dims.width - col_r : '0;
  assign cnt_err    = (cnt_len == '0) || ({{(DimW-LenW){1'b0}}, cnt_len} > room);
  assign step_len   = (phase_r == PH_RUN) ? pend_r : LenW'(1);
  assign col_new    = col_r + {{(DimW-LenW){1'b0}}, step_len};
  assign plane_end  = !(col_new < dims.width);
  assign last_ch    = (ch_r == ChLast);
  assign row_inc    = row_r + DimW'(1);
  assign img_end    = (row_inc >= dims.height);
  assign pend_dec   = (pend_r != '0) ? pend_r - LenW'(1) : pend_r;
  assign lit_last   = (pend_dec == '0);
  assign do_adv     = (phase_r == PH_RUN) || ((phase_r == PH_LITERAL) && lit_last);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    col_nxt   = col_r;
    ch_nxt    = ch_r;
    row_nxt   = row_r;
    pend_nxt  = pend_r;
    unique case (phase_r)
      PH_HEADER: begin
        hdr_nxt = hdr_r + HdrW'(1);
        if (hdr_r == HdrLast) begin
          hdr_nxt   = '0;
          col_nxt   = '0;
          ch_nxt    = '0;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (cnt_err) begin
          phase_nxt = PH_STOP;
        end else begin
          pend_nxt  = cnt_len;
          phase_nxt = is_run_cnt ? PH_RUN : PH_LITERAL;
        end
      end
      PH_RUN: begin
        col_nxt  = col_new;
        pend_nxt = '0;
      end
      PH_LITERAL: begin
        col_nxt  = col_new;
        pend_nxt = pend_dec;
      end
      PH_STOP: begin
        phase_nxt = PH_STOP;
      end
      default: begin
        phase_nxt = PH_STOP;
      end
    endcase
    if (do_adv) begin
      if (!plane_end) begin
        phase_nxt = PH_COUNT;
      end else begin
        col_nxt = '0;
        if (!last_ch) begin
          ch_nxt    = ch_r + ChW'(1);
          phase_nxt = PH_COUNT;
        end else begin
          ch_nxt    = '0;
          row_nxt   = img_end ? '0 : row_inc;
          hdr_nxt   = '0;
          phase_nxt = PH_HEADER;
        end
      end
    end
  end

  // result
  always_comb begin
    res.row_index     = row_r;
    res.channel_index = ch_r;
    res.start_column  = col_r;
    res.byte_value    = byte_in;
    res.run_length    = (phase_r == PH_COUNT) ? '0 : step_len;
    res.row_done      = do_adv && plane_end && last_ch;
    res.image_done    = do_adv && plane_end && last_ch && img_end;
    res.format_error  = (phase_r == PH_COUNT) && cnt_err;
    unique case (phase_r)
      PH_RUN, PH_LITERAL: res_valid = step;
      PH_COUNT:           res_valid = step && cnt_err;
      default:            res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hdr_r   <= '0;
      col_r   <= '0;
      ch_r    <= '0;
      row_r   <= '0;
      pend_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      col_r   <= col_nxt;
      ch_r    <= ch_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rsrd_checker.sv =====
// ----------------------------------------------------------------------------
// rsrd_checker
// port-level checks for the rgbe scanline run-length decoder
// ----------------------------------------------------------------------------
`default_nettype none

module rsrd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [1:0]  out_tuser
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  // error results carry zero length and close nothing, other results carry a length
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1] == (out_tdata[39:32] == 8'd0)) &&
                   !(out_tuser[1] && (out_tlast || out_tuser[0])))
    else $error("error flag and run length disagree");

  // image end only on a row end
  a_img_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("image_done without row_done");

  // decoder stops after an error
  a_err_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[1] |=> !out_tvalid)
    else $error("result after format error");

endmodule

bind rgbe_scanline_rle_decoder_unit rsrd_checker u_rsrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
